// ----- sv/lcdr_pkg.sv -----
package lcdr_pkg;

    localparam int GLYPH_W  = 40;   // glyph field width on the ports
    localparam int SLOT_W   = 3;    // slot field width on the ports
    localparam int REM_W    = 7;    // commands left in one refresh, up to 127
    localparam logic [7:0] SPACE_CODE = 8'h20;

    typedef enum logic [2:0] {
        ACT_CHAR    = 3'd0,
        ACT_GLYPH   = 3'd1,
        ACT_CLEAR   = 3'd2,
        ACT_REFRESH = 3'd3,
        ACT_POWER   = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        CMD_DEFINE = 2'd0,
        CMD_WRITE  = 2'd1,
        CMD_POWER  = 2'd2
    } t_command;

    typedef struct packed {
        logic [2:0]         action;
        logic [1:0]         cell_row;
        logic [4:0]         cell_col;
        logic [7:0]         char_code;
        logic [GLYPH_W-1:0] glyph_bits;
        logic               power_on;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]         command;
        logic [SLOT_W-1:0]  slot;
        logic [GLYPH_W-1:0] glyph_out;
        logic [1:0]         out_row;
        logic [4:0]         out_col;
        logic               move_cursor;
        logic [7:0]         code_out;
        logic               power_out;
        logic               last;
    } t_out_beat;

    // glyph lookup answer from the slot table
    typedef struct packed {
        logic              hit;
        logic              alloc;
        logic [SLOT_W-1:0] idx;
    } t_slot_res;

    // slot define step status
    typedef struct packed {
        logic       need;
        logic [3:0] total;
    } t_def_info;

endpackage

// ----- sv/char_lcd_refresh_engine_top.sv -----
// Channel | Valid       | Stall        | Payload
// input   | i_in_valid  | o_in_stall   | i_in  (t_in_beat)
// output  | o_out_valid | i_out_stall  | o_out (t_out_beat)
//
// Draw, clear and power beats are taken only in idle; input stalls while a result waits.
// Refresh: a scan over every cell, a count step, a define pass over the slots, then the
// write walk with an address and a data step per cell, holding while the output stalls.
// The address step is set by the single read port of the cell and shadow memories.
// Reset is synchronous; valid bits present the whole buffer as spaces at once.
// Clear drops all cell-store valid bits at once.
module char_lcd_refresh_engine_top #(
    parameter int ROWS       = 2,
    parameter int COLS       = 16,
    parameter int SLOTS      = 8,
    parameter int GLYPH_BITS = 40
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  lcdr_pkg::t_in_beat i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output lcdr_pkg::t_out_beat o_out
);
    import lcdr_pkg::*;

    localparam int CELLS = ROWS * COLS;
    localparam int IW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int CW    = $clog2(CELLS + 1);
    localparam int GW    = (GLYPH_BITS < GLYPH_W) ? GLYPH_BITS : GLYPH_W;
    localparam int SIW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SCW   = $clog2(SLOTS + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_DCNT, S_DEF, S_WADDR, S_WDATA
    } t_state;

    t_state         r_state, n_state;
    logic [CW-1:0]  r_ra, n_ra;         // scan read address
    logic           r_pv, n_pv;         // scan data in flight
    logic [IW-1:0]  r_pa, n_pa;         // address of scan data
    logic [REM_W-1:0] r_wcnt, n_wcnt;   // cells that differ
    logic [REM_W-1:0] r_rem, n_rem;     // commands still to send
    logic [SIW-1:0] r_s, n_s;
    logic [IW-1:0]  r_j, n_j;
    logic [1:0]     r_wr, n_wr;
    logic [4:0]     r_wc, n_wc;
    logic           r_ck, n_ck;
    logic [1:0]     r_crow, n_crow;
    logic [5:0]     r_ccol, n_ccol;
    logic           r_pwr, n_pwr;
    logic           r_ov, n_ov;
    t_out_beat      r_out, n_out;

    // shadow of the display contents and scan results
    logic [7:0]     r_shm [CELLS];
    logic [CELLS-1:0] r_shv;
    logic [7:0]     r_shrd;
    logic           r_shrv;
    logic [8:0]     r_fm [CELLS];
    logic [8:0]     r_fmrd;

    logic           acc;
    logic           out_free;
    logic           in_bounds;
    logic [IW-1:0]  in_idx;
    logic           cs_wr;
    logic           cs_is_g;
    logic [7:0]     cs_code;
    logic [GW-1:0]  cs_glyph;
    logic           cam_clr;
    logic           look_en;
    t_slot_res      sres;
    t_def_info      dinf;
    logic [GW-1:0]  def_glyph;
    logic           def_take;
    logic [7:0]     fresh;
    logic [7:0]     shown;
    logic           diff;

    assign o_in_stall  = (r_state != S_IDLE) || r_ov;
    assign acc         = i_in_valid && !o_in_stall;
    assign out_free    = !r_ov || !i_out_stall;
    assign o_out_valid = r_ov;
    assign o_out       = r_out;

    assign in_bounds = (int'(i_in.cell_row) < ROWS) && (int'(i_in.cell_col) < COLS);
    assign in_idx    = IW'(int'(i_in.cell_row) * COLS + int'(i_in.cell_col));
    assign cs_wr     = acc && in_bounds &&
                       ((i_in.action == ACT_CHAR) || (i_in.action == ACT_GLYPH));
    assign cam_clr   = acc && (i_in.action == ACT_REFRESH);

    lcdr_cell_store #(.CELLS(CELLS), .GW(GW), .IW(IW)) u_cells (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_clr         (acc && (i_in.action == ACT_CLEAR)),
        .i_wr_en       (cs_wr),
        .i_wr_idx      (in_idx),
        .i_wr_is_glyph (i_in.action == ACT_GLYPH),
        .i_wr_code     (i_in.char_code),
        .i_wr_glyph    (i_in.glyph_bits[GW-1:0]),
        .i_rd_idx      (r_ra[IW-1:0]),
        .o_rd_is_glyph (cs_is_g),
        .o_rd_code     (cs_code),
        .o_rd_glyph    (cs_glyph)
    );

    assign look_en = (r_state == S_SCAN) && r_pv && cs_is_g;

    lcdr_slot_cam #(.SLOTS(SLOTS), .GW(GW), .SIW(SIW), .SCW(SCW)) u_cam (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clr       (cam_clr),
        .i_look_en   (look_en),
        .i_glyph     (cs_glyph),
        .o_res       (sres),
        .i_def_idx   (r_s),
        .i_def_take  (def_take),
        .o_def       (dinf),
        .o_def_glyph (def_glyph)
    );

    // new code for the cell under scan
    always_comb begin
        if (!cs_is_g) begin
            fresh = cs_code;
        end else if (sres.hit || sres.alloc) begin
            fresh = 8'(sres.idx);
        end else begin
            fresh = SPACE_CODE;
        end
        shown = r_shrv ? r_shrd : SPACE_CODE;
        diff  = (fresh != shown);
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_SCAN) && r_pv) begin
            r_shm[r_pa] <= fresh;
            r_fm[r_pa]  <= {diff, fresh};
        end
        r_shrd <= r_shm[r_ra[IW-1:0]];
        r_fmrd <= r_fm[r_j];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shv  <= '0;
            r_shrv <= 1'b0;
        end else begin
            if ((r_state == S_SCAN) && r_pv) begin
                r_shv[r_pa] <= 1'b1;
            end
            r_shrv <= r_shv[r_ra[IW-1:0]];
        end
    end

    assign def_take = (r_state == S_DEF) && dinf.need && out_free;

    always_comb begin
        n_state = r_state;
        n_ra    = r_ra;
        n_pv    = r_pv;
        n_pa    = r_pa;
        n_wcnt  = r_wcnt;
        n_rem   = r_rem;
        n_s     = r_s;
        n_j     = r_j;
        n_wr    = r_wr;
        n_wc    = r_wc;
        n_ck    = r_ck;
        n_crow  = r_crow;
        n_ccol  = r_ccol;
        n_pwr   = r_pwr;
        n_ov    = r_ov && i_out_stall;
        n_out   = r_out;

        unique case (r_state)
            S_IDLE: begin
                if (acc && (i_in.action == ACT_REFRESH)) begin
                    n_state = S_SCAN;
                    n_ra    = '0;
                    n_pv    = 1'b0;
                    n_wcnt  = '0;
                end else if (acc && (i_in.action == ACT_POWER) &&
                             (i_in.power_on != r_pwr)) begin
                    n_pwr           = i_in.power_on;
                    n_ov            = 1'b1;
                    n_out           = '0;
                    n_out.command   = CMD_POWER;
                    n_out.power_out = i_in.power_on;
                    n_out.last      = 1'b1;
                end
            end
            S_SCAN: begin
                if (r_pv && diff) begin
                    n_wcnt = r_wcnt + 1'b1;
                end
                if (r_ra != CW'(CELLS)) begin
                    n_ra = r_ra + 1'b1;
                    n_pv = 1'b1;
                    n_pa = r_ra[IW-1:0];
                end else begin
                    n_pv = 1'b0;
                    if (!r_pv) begin
                        n_state = S_DCNT;
                    end
                end
            end
            S_DCNT: begin
                n_rem = REM_W'(dinf.total) + r_wcnt;
                n_s   = '0;
                n_j   = '0;
                n_wr  = '0;
                n_wc  = '0;
                n_state = (n_rem == '0) ? S_IDLE : S_DEF;
            end
            S_DEF: begin
                if (!dinf.need || out_free) begin
                    if (dinf.need) begin
                        n_ov            = 1'b1;
                        n_out           = '0;
                        n_out.command   = CMD_DEFINE;
                        n_out.slot      = SLOT_W'(r_s);
                        n_out.glyph_out = GLYPH_W'(def_glyph);
                        n_out.last      = (r_rem == REM_W'(1));
                        n_rem           = r_rem - 1'b1;
                    end
                    if (r_s == SIW'(SLOTS - 1)) begin
                        n_state = S_WADDR;
                    end else begin
                        n_s = r_s + 1'b1;
                    end
                end
            end
            S_WADDR: begin
                n_state = S_WDATA;
            end
            S_WDATA: begin
                if (!r_fmrd[8] || out_free) begin
                    if (r_fmrd[8]) begin
                        n_ov              = 1'b1;
                        n_out             = '0;
                        n_out.command     = CMD_WRITE;
                        n_out.out_row     = r_wr;
                        n_out.out_col     = r_wc;
                        n_out.move_cursor = !(r_ck && (r_crow == r_wr) &&
                                              (r_ccol == {1'b0, r_wc}));
                        n_out.code_out    = r_fmrd[7:0];
                        n_out.last        = (r_rem == REM_W'(1));
                        n_rem             = r_rem - 1'b1;
                        n_ck              = 1'b1;
                        n_crow            = r_wr;
                        n_ccol            = {1'b0, r_wc} + 1'b1;
                    end
                    if (r_j == IW'(CELLS - 1)) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_WADDR;
                        n_j     = r_j + 1'b1;
                        if (r_wc == 5'(COLS - 1)) begin
                            n_wc = '0;
                            n_wr = r_wr + 1'b1;
                        end else begin
                            n_wc = r_wc + 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ra    <= '0;
            r_pv    <= 1'b0;
            r_wcnt  <= '0;
            r_rem   <= '0;
            r_s     <= '0;
            r_j     <= '0;
            r_wr    <= '0;
            r_wc    <= '0;
            r_ck    <= 1'b0;
            r_crow  <= '0;
            r_ccol  <= '0;
            r_pwr   <= 1'b1;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ra    <= n_ra;
            r_pv    <= n_pv;
            r_wcnt  <= n_wcnt;
            r_rem   <= n_rem;
            r_s     <= n_s;
            r_j     <= n_j;
            r_wr    <= n_wr;
            r_wc    <= n_wc;
            r_ck    <= n_ck;
            r_crow  <= n_crow;
            r_ccol  <= n_ccol;
            r_pwr   <= n_pwr;
            r_ov    <= n_ov;
        end
        r_pa  <= n_pa;
        r_out <= n_out;
    end

endmodule

// ----- sv/lcdr_cell_store.sv -----
module lcdr_cell_store #(
    parameter int CELLS = 32,
    parameter int GW    = 40,
    parameter int IW    = 5
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_clr,
    input  logic          i_wr_en,
    input  logic [IW-1:0] i_wr_idx,
    input  logic          i_wr_is_glyph,
    input  logic [7:0]    i_wr_code,
    input  logic [GW-1:0] i_wr_glyph,
    input  logic [IW-1:0] i_rd_idx,
    output logic          o_rd_is_glyph,
    output logic [7:0]    o_rd_code,
    output logic [GW-1:0] o_rd_glyph
);
    import lcdr_pkg::*;

    logic [GW+8:0] r_mem [CELLS];
    logic [CELLS-1:0] r_vld;
    logic [GW+8:0] r_rd;
    logic          r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= {i_wr_is_glyph, i_wr_code, i_wr_glyph};
        end
        r_rd <= r_mem[i_rd_idx];
    end

    // valid bits: an invalid entry reads as a blank space cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_idx] <= 1'b1;
            end
            r_rd_vld <= r_vld[i_rd_idx];
        end
    end

    assign o_rd_is_glyph = r_rd_vld & r_rd[GW+8];
    assign o_rd_code     = r_rd_vld ? r_rd[GW+7:GW] : SPACE_CODE;
    assign o_rd_glyph    = r_rd[GW-1:0];

endmodule

// ----- sv/lcdr_slot_cam.sv -----
module lcdr_slot_cam #(
    parameter int SLOTS = 8,
    parameter int GW    = 40,
    parameter int SIW   = 3,
    parameter int SCW   = 4
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_clr,
    input  logic                   i_look_en,
    input  logic [GW-1:0]          i_glyph,
    output lcdr_pkg::t_slot_res    o_res,
    input  logic [SIW-1:0]         i_def_idx,
    input  logic                   i_def_take,
    output lcdr_pkg::t_def_info    o_def,
    output logic [GW-1:0]          o_def_glyph
);
    import lcdr_pkg::*;

    logic [GW-1:0]  r_pg [SLOTS];   // slots given out in this refresh
    logic [GW-1:0]  r_sg [SLOTS];   // glyphs last sent to the display
    logic [SCW-1:0] r_pc;
    logic [SLOTS-1:0] hit_vec;
    logic [SLOTS-1:0] need_vec;
    t_slot_res res;

    always_comb begin
        for (int s = 0; s < SLOTS; s++) begin
            hit_vec[s]  = (SCW'(s) < r_pc) && (r_pg[s] == i_glyph);
            need_vec[s] = (SCW'(s) < r_pc) && (r_pg[s] != r_sg[s]);
        end
    end

    always_comb begin
        res.hit   = 1'b0;
        res.alloc = 1'b0;
        res.idx   = SLOT_W'(r_pc);
        for (int s = SLOTS - 1; s >= 0; s--) begin
            if (hit_vec[s]) begin
                res.hit = 1'b1;
                res.idx = SLOT_W'(s);
            end
        end
        if (!res.hit && (r_pc < SCW'(SLOTS))) begin
            res.alloc = 1'b1;
        end
    end

    assign o_res = res;

    always_comb begin
        o_def.need  = need_vec[i_def_idx];
        o_def.total = '0;
        for (int s = 0; s < SLOTS; s++) begin
            o_def.total = o_def.total + 4'(need_vec[s]);
        end
    end

    assign o_def_glyph = r_pg[i_def_idx];

    always_ff @(posedge i_clk) begin
        if (i_look_en && res.alloc) begin
            r_pg[r_pc[SIW-1:0]] <= i_glyph;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= '0;
            for (int s = 0; s < SLOTS; s++) begin
                r_sg[s] <= '0;
            end
        end else begin
            if (i_clr) begin
                r_pc <= '0;
            end else if (i_look_en && res.alloc) begin
                r_pc <= r_pc + 1'b1;
            end
            if (i_def_take) begin
                r_sg[i_def_idx] <= r_pg[i_def_idx];
            end
        end
    end

endmodule

// ----- sv/lcdr_checker.sv -----
module lcdr_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input lcdr_pkg::t_out_beat o_out
);
    import lcdr_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("output beat dropped while stalled");

    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid straight after reset");

    a_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input taken while a result waits");

    a_power_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.command == CMD_POWER) |-> o_out.last)
        else $error("power command not last");

    a_define_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.command == CMD_DEFINE) |->
            (o_out.code_out == 8'd0) && !o_out.move_cursor && !o_out.power_out)
        else $error("define beat carries write fields");

endmodule

bind char_lcd_refresh_engine_top lcdr_checker u_lcdr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);
